// ----- rtl/ksm_pkg.sv -----
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared constants, state encoding and control/status bundles of the key
// sequence matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

   localparam int NUM_SEQ_DEF   = 8;
   localparam int MAX_LEN_DEF   = 16;

   localparam int CODE_W        = 8;
   localparam int SEQ_SLOT_W    = 3;
   localparam int ENTRY_SLOT_W  = 4;
   localparam int MASK_W        = 8;
   localparam int CSR_IDX_W     = 2;

   // table entry layout
   localparam int ENT_W         = 11;
   localparam int ENT_CTRL_BIT  = 8;
   localparam int ENT_SHIFT_BIT = 9;
   localparam int ENT_ALT_BIT   = 10;

   localparam logic REQ_KEY_EVENT   = 1'b0;
   localparam logic REQ_TABLE_WRITE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEQ_ENABLE   = 2'd0,
      CSR_STRICT_MASK  = 2'd1,
      CSR_CONSUME_MASK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SEEK,
      ST_COMPARE,
      ST_TERM,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic tbl_write;
      logic rd_next;
      logic pos_zero;
      logic pos_next;
      logic mark_done;
      logic set_consumed;
      logic slot_next;
   } ctl_type;

   typedef struct packed {
      logic clr_last;
      logic is_write;
      logic is_press;
      logic slot_en;
      logic slot_last;
      logic hit;
      logic next_in_range;
      logic term;
      logic consume_bit;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/ksm_ram.sv -----
// ----------------------------------------------------------------------------
// ksm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/ksm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ksm_ctrl
// Sequencer: clearing pass after reset, item decode and the per-slot scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire ksm_pkg::stat_type stat,
   output ksm_pkg::ctl_type       ctl
);

   ksm_pkg::state_type state_ff;
   ksm_pkg::state_type state_in;
   logic               advance;
   logic               complete;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      advance  = 1'b0;
      complete = 1'b0;

      unique case (state_ff)
         ksm_pkg::ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ksm_pkg::ST_IDLE;
            end
         end
         ksm_pkg::ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ksm_pkg::ST_DECODE;
            end
         end
         ksm_pkg::ST_DECODE: begin
            if (stat.is_write) begin
               ctl.tbl_write = 1'b1;
               state_in      = ksm_pkg::ST_RESP;
            end else if (stat.is_press) begin
               state_in = ksm_pkg::ST_SEEK;
            end else begin
               state_in = ksm_pkg::ST_RESP;
            end
         end
         ksm_pkg::ST_SEEK: begin
            if (stat.slot_en) begin
               state_in = ksm_pkg::ST_COMPARE;
            end else begin
               advance = 1'b1;
            end
         end
         ksm_pkg::ST_COMPARE: begin
            if (!stat.hit) begin
               ctl.pos_zero = 1'b1;
               advance      = 1'b1;
            end else if (!stat.next_in_range) begin
               complete = 1'b1;
            end else begin
               ctl.rd_next = 1'b1;
               state_in    = ksm_pkg::ST_TERM;
            end
         end
         ksm_pkg::ST_TERM: begin
            if (stat.term) begin
               complete = 1'b1;
            end else begin
               ctl.pos_next = 1'b1;
               advance      = 1'b1;
            end
         end
         ksm_pkg::ST_RESP: begin
            state_in = ksm_pkg::ST_IDLE;
         end
         default: begin
            state_in = ksm_pkg::ST_IDLE;
         end
      endcase

      // a completion marks the slot done and resets its position; a consuming one ends the scan early
      if (complete) begin
         ctl.pos_zero  = 1'b1;
         ctl.mark_done = 1'b1;
         if (stat.consume_bit) begin
            ctl.set_consumed = 1'b1;
            state_in         = ksm_pkg::ST_RESP;
         end else begin
            advance = 1'b1;
         end
      end

      if (advance) begin
         if (stat.slot_last) begin
            state_in = ksm_pkg::ST_RESP;
         end else begin
            ctl.slot_next = 1'b1;
            state_in      = ksm_pkg::ST_SEEK;
         end
      end
   end

   assign busy      = (state_ff != ksm_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ksm_pkg::ST_RESP);

endmodule

`default_nettype wire

// ----- rtl/ksm_datapath.sv -----
// ----------------------------------------------------------------------------
// ksm_datapath
// Item capture, control registers, sequence table, match positions and the
// compare logic for one slot at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_datapath #(
   parameter int NUM_SEQ = ksm_pkg::NUM_SEQ_DEF,
   parameter int MAX_LEN = ksm_pkg::MAX_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ksm_pkg::ctl_type                    ctl,
   output ksm_pkg::stat_type                        stat,
   input  wire logic                                csr_we,
   input  wire logic [ksm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ksm_pkg::MASK_W-1:0]          csr_wdata,
   input  wire logic                                req_type,
   input  wire logic [ksm_pkg::CODE_W-1:0]          req_key_code,
   input  wire logic                                req_ctrl_down,
   input  wire logic                                req_shift_down,
   input  wire logic                                req_alt_down,
   input  wire logic                                req_is_key_down,
   input  wire logic [ksm_pkg::SEQ_SLOT_W-1:0]      req_seq_slot,
   input  wire logic [ksm_pkg::ENTRY_SLOT_W-1:0]    req_entry_slot,
   output logic      [ksm_pkg::MASK_W-1:0]          rsp_completed_mask,
   output logic                                     rsp_consumed
);

   localparam int DEPTH  = NUM_SEQ * MAX_LEN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = (NUM_SEQ > 1) ? $clog2(NUM_SEQ) : 1;
   localparam int POS_W  = $clog2(MAX_LEN);

   // captured item
   logic                               type_ff;
   logic [ksm_pkg::CODE_W-1:0]         code_ff;
   logic [2:0]                         mods_ff;
   logic                               press_ff;
   logic [ksm_pkg::SEQ_SLOT_W-1:0]     seq_ff;
   logic [ksm_pkg::ENTRY_SLOT_W-1:0]   entry_ff;

   logic [ksm_pkg::MASK_W-1:0]         seq_enable_ff;
   logic [ksm_pkg::MASK_W-1:0]         strict_mask_ff;
   logic [ksm_pkg::MASK_W-1:0]         consume_mask_ff;

   logic [NUM_SEQ-1:0]                 en_vec;
   logic [NUM_SEQ-1:0]                 strict_vec;
   logic [NUM_SEQ-1:0]                 consume_vec;

   logic [SLOT_W-1:0]                  slot_ff;
   logic [POS_W-1:0]                   pos_ff [NUM_SEQ];
   logic [ADDR_W-1:0]                  clr_ff;
   logic [NUM_SEQ-1:0]                 done_ff;
   logic                               consumed_ff;

   logic [POS_W-1:0]                   pos_cur;
   logic [POS_W:0]                     pos_inc;
   logic [POS_W-1:0]                   rd_pos;
   logic [ADDR_W-1:0]                  rd_addr;
   logic [ADDR_W-1:0]                  wr_addr;
   logic [ksm_pkg::ENT_W-1:0]          wr_data;
   logic                               wr_en;
   logic                               wr_in_range;
   logic [SLOT_W-1:0]                  wr_slot;
   logic [ksm_pkg::ENT_W-1:0]          rd_data;
   logic [2:0]                         ent_mods;

   // slots beyond the register width have no enable, strict or consume bit
   for (genvar i = 0; i < NUM_SEQ; i++) begin : g_mask
      if (i < ksm_pkg::MASK_W) begin : g_bit
         assign en_vec[i]      = seq_enable_ff[i];
         assign strict_vec[i]  = strict_mask_ff[i];
         assign consume_vec[i] = consume_mask_ff[i];
      end else begin : g_none
         assign en_vec[i]      = 1'b0;
         assign strict_vec[i]  = 1'b0;
         assign consume_vec[i] = 1'b0;
      end
   end

   for (genvar k = 0; k < ksm_pkg::MASK_W; k++) begin : g_out
      if (k < NUM_SEQ) begin : g_bit
         assign rsp_completed_mask[k] = done_ff[k];
      end else begin : g_none
         assign rsp_completed_mask[k] = 1'b0;
      end
   end
   assign rsp_consumed = consumed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_enable_ff   <= '0;
         strict_mask_ff  <= '0;
         consume_mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ksm_pkg::CSR_SEQ_ENABLE:   seq_enable_ff   <= csr_wdata;
            ksm_pkg::CSR_STRICT_MASK:  strict_mask_ff  <= csr_wdata;
            ksm_pkg::CSR_CONSUME_MASK: consume_mask_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         type_ff  <= req_type;
         code_ff  <= req_key_code;
         mods_ff  <= {req_alt_down, req_shift_down, req_ctrl_down};
         press_ff <= req_is_key_down;
         seq_ff   <= req_seq_slot;
         entry_ff <= req_entry_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         done_ff     <= '0;
         consumed_ff <= 1'b0;
      end else begin
         if (ctl.mark_done) begin
            done_ff[slot_ff] <= 1'b1;
         end
         if (ctl.set_consumed) begin
            consumed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (ctl.load) begin
            slot_ff <= '0;
         end else if (ctl.slot_next) begin
            slot_ff <= slot_ff + 1'b1;
         end
         if (ctl.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   assign wr_in_range = (int'(seq_ff) < NUM_SEQ) && (int'(entry_ff) < MAX_LEN);
   assign wr_slot     = SLOT_W'(seq_ff);
   assign pos_cur     = pos_ff[slot_ff];
   assign pos_inc     = {1'b0, pos_cur} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEQ; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (ctl.tbl_write && wr_in_range) begin
         pos_ff[wr_slot] <= '0;
      end else if (ctl.pos_zero) begin
         pos_ff[slot_ff] <= '0;
      end else if (ctl.pos_next) begin
         pos_ff[slot_ff] <= pos_inc[POS_W-1:0];
      end
   end

   // table port: clearing pass has the write side to itself
   always_comb begin
      if (ctl.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = ctl.tbl_write && wr_in_range;
         wr_addr = ADDR_W'(seq_ff) * ADDR_W'(MAX_LEN) + ADDR_W'(entry_ff);
         wr_data = {mods_ff, code_ff};
      end
   end

   assign rd_pos  = ctl.rd_next ? pos_inc[POS_W-1:0] : pos_cur;
   assign rd_addr = ADDR_W'(slot_ff) * ADDR_W'(MAX_LEN) + ADDR_W'(rd_pos);

   ksm_ram #(
      .WIDTH (ksm_pkg::ENT_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign ent_mods = {rd_data[ksm_pkg::ENT_ALT_BIT], rd_data[ksm_pkg::ENT_SHIFT_BIT],
                      rd_data[ksm_pkg::ENT_CTRL_BIT]};

   always_comb begin
      stat               = '0;
      stat.clr_last      = (clr_ff == ADDR_W'(DEPTH - 1));
      stat.is_write      = (type_ff == ksm_pkg::REQ_TABLE_WRITE);
      stat.is_press      = (type_ff == ksm_pkg::REQ_KEY_EVENT) && press_ff;
      stat.slot_en       = en_vec[slot_ff];
      stat.slot_last     = (slot_ff == SLOT_W'(NUM_SEQ - 1));
      stat.hit           = (code_ff != '0) && (code_ff == rd_data[ksm_pkg::CODE_W-1:0]) &&
                           (!strict_vec[slot_ff] || (ent_mods == mods_ff));
      stat.next_in_range = (int'(pos_inc) < MAX_LEN);
      stat.term          = (rd_data[ksm_pkg::CODE_W-1:0] == '0);
      stat.consume_bit   = consume_vec[slot_ff];
   end

endmodule

`default_nettype wire

// ----- rtl/key_sequence_matcher_top.sv -----
// ----------------------------------------------------------------------------
// key_sequence_matcher_top
// Matches key-down events against a table of registered key sequences.
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low. req_type selects a
//   key event or a write of one table entry (seq_slot, entry_slot).
//   every item gives exactly one result: rsp_valid is high for one cycle with
//   rsp_completed_mask and rsp_consumed (both zero for a write or a release).
//   the receiver cannot stall; results must be taken when strobed.
//   csr_we writes seq_enable, strict_mask or consume_mask by csr_index; the
//   user is to do so only while the block is idle, which the block does not
//   enforce: a write is taken at once, also during the clearing pass.
//   a table write or key release goes from decode to the result. a key press
//   scans the slots in order, passing over disabled ones; a consuming
//   completion ends the scan. the table read is registered: an enabled slot
//   reads its expected entry and, after a hit short of the last entry, once
//   more for the terminator check.
// throughput:
//   one item at a time; busy stays high through the result cycle, so a new
//   item is taken only once the block is back in idle.
// reset:
//   positions and registers clear at once; the table is then zeroed one
//   entry a cycle, with busy high, before an item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module key_sequence_matcher_top #(
   parameter int NUM_SEQ = ksm_pkg::NUM_SEQ_DEF,
   parameter int MAX_LEN = ksm_pkg::MAX_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_type,
   input  wire logic [ksm_pkg::CODE_W-1:0]          req_key_code,
   input  wire logic                                req_ctrl_down,
   input  wire logic                                req_shift_down,
   input  wire logic                                req_alt_down,
   input  wire logic                                req_is_key_down,
   input  wire logic [ksm_pkg::SEQ_SLOT_W-1:0]      req_seq_slot,
   input  wire logic [ksm_pkg::ENTRY_SLOT_W-1:0]    req_entry_slot,
   output logic                                     rsp_valid,
   output logic      [ksm_pkg::MASK_W-1:0]          rsp_completed_mask,
   output logic                                     rsp_consumed,
   input  wire logic                                csr_we,
   input  wire logic [ksm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ksm_pkg::MASK_W-1:0]          csr_wdata
);

   ksm_pkg::ctl_type  ctl;
   ksm_pkg::stat_type stat;

   ksm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .ctl       (ctl)
   );

   ksm_datapath #(
      .NUM_SEQ (NUM_SEQ),
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_key_code       (req_key_code),
      .req_ctrl_down      (req_ctrl_down),
      .req_shift_down     (req_shift_down),
      .req_alt_down       (req_alt_down),
      .req_is_key_down    (req_is_key_down),
      .req_seq_slot       (req_seq_slot),
      .req_entry_slot     (req_entry_slot),
      .rsp_completed_mask (rsp_completed_mask),
      .rsp_consumed       (rsp_consumed)
   );

endmodule

`default_nettype wire

// ----- sim/tb_key_sequence_matcher_top.sv -----
// ----------------------------------------------------------------------------
// tb_key_sequence_matcher_top
// Self-checking bench for the key sequence matcher. Table writes and key
// events are driven through the start/busy port while a scoreboard keeps its
// own copy of the sequence table, the match positions and the mask registers,
// and compares every strobed result against its prediction.
// ----------------------------------------------------------------------------

module tb_key_sequence_matcher_top;

   localparam int NUM_SLOTS      = ksm_pkg::NUM_SEQ_DEF;
   localparam int SLOT_LEN       = ksm_pkg::MAX_LEN_DEF;
   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 2 + 3 * NUM_SLOTS;
   localparam int MAX_GAP        = 40;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [ksm_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic                               req_type;
      logic [ksm_pkg::CODE_W-1:0]         key_code;
      logic                               ctrl;
      logic                               shift;
      logic                               alt;
      logic                               press;
      logic [ksm_pkg::SEQ_SLOT_W-1:0]     seq_slot;
      logic [ksm_pkg::ENTRY_SLOT_W-1:0]   entry_slot;
   } key_item_type;

   typedef struct packed {
      logic [ksm_pkg::MASK_W-1:0] completed_mask;
      logic                       consumed;
   } match_result_type;

   class match_scoreboard;
      logic [ksm_pkg::ENT_W-1:0]        entries [NUM_SLOTS * SLOT_LEN];
      logic [ksm_pkg::ENTRY_SLOT_W-1:0] position [NUM_SLOTS];
      logic [ksm_pkg::MASK_W-1:0]       seq_enable;
      logic [ksm_pkg::MASK_W-1:0]       strict_mask;
      logic [ksm_pkg::MASK_W-1:0]       consume_mask;
      match_result_type                 pending_results [$];
      int                               errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         foreach (position[i]) position[i] = '0;
         seq_enable   = '0;
         strict_mask  = '0;
         consume_mask = '0;
         errors       = 0;
      endfunction

      function void set_reg(logic [ksm_pkg::CSR_IDX_W-1:0] idx,
                            logic [ksm_pkg::MASK_W-1:0] value);
         case (idx)
            ksm_pkg::CSR_SEQ_ENABLE:   seq_enable   = value;
            ksm_pkg::CSR_STRICT_MASK:  strict_mask  = value;
            ksm_pkg::CSR_CONSUME_MASK: consume_mask = value;
            default: ;
         endcase
      endfunction

      function match_result_type predict_match(key_item_type it);
         match_result_type          r;
         logic [2:0]                mods;
         logic [ksm_pkg::ENT_W-1:0] cur;
         logic                      hit;
         int                        pos;
         r    = '0;
         mods = {it.alt, it.shift, it.ctrl};
         if (it.req_type == ksm_pkg::REQ_TABLE_WRITE) begin
            entries[it.seq_slot * SLOT_LEN + it.entry_slot] = {mods, it.key_code};
            position[it.seq_slot] = '0;
         end else if (it.press) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!seq_enable[i]) continue;
               pos = int'(position[i]);
               cur = entries[i * SLOT_LEN + pos];
               hit = (it.key_code != 8'h00) && (it.key_code == cur[7:0]);
               if (hit && strict_mask[i]) hit = (cur[10:8] == mods);
               if (!hit) begin
                  position[i] = '0;
                  continue;
               end
               pos++;
               if (pos >= SLOT_LEN || entries[i * SLOT_LEN + pos][7:0] == 8'h00) begin
                  position[i] = '0;
                  r.completed_mask[i] = 1'b1;
                  if (consume_mask[i]) begin
                     r.consumed = 1'b1;
                     break;
                  end
               end else begin
                  position[i] = 4'(pos);
               end
            end
         end
         return r;
      endfunction

      function void note_item(key_item_type it);
         match_result_type want;
         want            = predict_match(it);
         pending_results = {pending_results, want};
      endfunction

      function void check_result(logic [ksm_pkg::MASK_W-1:0] mask, logic consumed);
         match_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with no item waiting: completed_mask %h consumed %0b",
                   mask, consumed);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (mask !== want.completed_mask) begin
            $error("completed_mask: expected %h, got %h", want.completed_mask, mask);
            errors++;
         end
         if (consumed !== want.consumed) begin
            $error("consumed: expected %0b, got %0b", want.consumed, consumed);
            errors++;
         end
      endfunction
   endclass

   logic                               clock           = 1'b0;
   logic                               reset           = 1'b1;
   logic                               start           = 1'b0;
   logic                               busy;
   logic                               req_type        = 1'b0;
   logic [ksm_pkg::CODE_W-1:0]         req_key_code    = '0;
   logic                               req_ctrl_down   = 1'b0;
   logic                               req_shift_down  = 1'b0;
   logic                               req_alt_down    = 1'b0;
   logic                               req_is_key_down = 1'b0;
   logic [ksm_pkg::SEQ_SLOT_W-1:0]     req_seq_slot    = '0;
   logic [ksm_pkg::ENTRY_SLOT_W-1:0]   req_entry_slot  = '0;
   logic                               rsp_valid;
   logic [ksm_pkg::MASK_W-1:0]         rsp_completed_mask;
   logic                               rsp_consumed;
   logic                               csr_we          = 1'b0;
   logic [ksm_pkg::CSR_IDX_W-1:0]      csr_index       = '0;
   logic [ksm_pkg::MASK_W-1:0]         csr_wdata       = '0;

   match_scoreboard board = new();

   // stimulus-side picture of what each slot was loaded with
   logic [ksm_pkg::ENT_W-1:0] script [NUM_SLOTS][SLOT_LEN];
   int                        script_len [NUM_SLOTS];
   logic [7:0]                common_keys [4] = '{8'h01, 8'h41, 8'h80, 8'hFE};
   int                        sender_idle_pct = 0;
   int                        items_sent      = 0;

   key_sequence_matcher_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_key_code       (req_key_code),
      .req_ctrl_down      (req_ctrl_down),
      .req_shift_down     (req_shift_down),
      .req_alt_down       (req_alt_down),
      .req_is_key_down    (req_is_key_down),
      .req_seq_slot       (req_seq_slot),
      .req_entry_slot     (req_entry_slot),
      .rsp_valid          (rsp_valid),
      .rsp_completed_mask (rsp_completed_mask),
      .rsp_consumed       (rsp_consumed),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.set_reg(csr_index, csr_wdata);
         if (start && !busy) begin
            board.note_item('{req_type, req_key_code, req_ctrl_down, req_shift_down,
                              req_alt_down, req_is_key_down, req_seq_slot,
                              req_entry_slot});
         end
         if (rsp_valid) board.check_result(rsp_completed_mask, rsp_consumed);
      end
   end

   function automatic key_item_type table_item(int slot, int entry, logic [7:0] code,
                                               logic [2:0] mods);
      key_item_type it;
      it.req_type   = ksm_pkg::REQ_TABLE_WRITE;
      it.key_code   = code;
      it.ctrl       = mods[0];
      it.shift      = mods[1];
      it.alt        = mods[2];
      it.press      = 1'($urandom_range(0, 1));
      it.seq_slot   = 3'(slot);
      it.entry_slot = 4'(entry);
      return it;
   endfunction

   function automatic key_item_type key_event(logic [7:0] code, logic [2:0] mods,
                                              logic down);
      key_item_type it;
      it.req_type   = ksm_pkg::REQ_KEY_EVENT;
      it.key_code   = code;
      it.ctrl       = mods[0];
      it.shift      = mods[1];
      it.alt        = mods[2];
      it.press      = down;
      it.seq_slot   = 3'($urandom_range(0, NUM_SLOTS - 1));
      it.entry_slot = 4'($urandom_range(0, SLOT_LEN - 1));
      return it;
   endfunction

   function automatic logic [7:0] pick_mask();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // start stays high when items follow back to back
   task automatic send_item(input key_item_type it);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= it.req_type;
      req_key_code    <= it.key_code;
      req_ctrl_down   <= it.ctrl;
      req_shift_down  <= it.shift;
      req_alt_down    <= it.alt;
      req_is_key_down <= it.press;
      req_seq_slot    <= it.seq_slot;
      req_entry_slot  <= it.entry_slot;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic drain_block();
      start <= 1'b0;
      @(posedge clock);
      while (busy || board.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ksm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ksm_pkg::MASK_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_masks(input logic [7:0] enable, input logic [7:0] strict,
                            input logic [7:0] consume);
      write_reg(ksm_pkg::CSR_SEQ_ENABLE, enable);
      write_reg(ksm_pkg::CSR_STRICT_MASK, strict);
      write_reg(ksm_pkg::CSR_CONSUME_MASK, consume);
      // the spare index must not disturb anything
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNMAPPED, 8'($urandom_range(0, 255)));
      csr_we <= 1'b0;
   endtask

   task automatic run_directed();
      write_reg(CSR_UNMAPPED, 8'hFF);
      set_masks(8'hFF, 8'h02, 8'h00);
      send_item(table_item(0, 0, 8'hFF, 3'b111));
      send_item(table_item(0, 1, 8'h01, 3'b000));
      send_item(table_item(0, 2, 8'h00, 3'b111));
      send_item(table_item(1, 0, 8'h41, 3'b001));
      send_item(table_item(1, 1, 8'h00, 3'b000));
      // slot 7 stays empty: its first entry is still a terminator
      send_item(table_item(7, 15, 8'h80, 3'b101));
      send_item(key_event(8'hFF, 3'b111, 1'b1));
      send_item(key_event(8'h01, 3'b000, 1'b0));
      send_item(key_event(8'h01, 3'b010, 1'b1));
      // strict slot: code right, modifiers wrong, then right
      send_item(key_event(8'h41, 3'b000, 1'b1));
      send_item(key_event(8'h41, 3'b001, 1'b1));
      send_item(key_event(8'hFF, 3'b000, 1'b1));
      send_item(key_event(8'h00, 3'b000, 1'b1));
      send_item(key_event(8'h01, 3'b000, 1'b1));
      send_item(table_item(2, 0, 8'h01, 3'b000));
      send_item(table_item(2, 1, 8'h00, 3'b000));
      // consuming completion of slot 0 hides slot 2 from the event
      drain_block();
      set_masks(8'hFF, 8'h00, 8'h01);
      send_item(key_event(8'hFF, 3'b000, 1'b1));
      send_item(key_event(8'h01, 3'b000, 1'b1));
      send_item(key_event(8'h01, 3'b000, 1'b1));
      // a disabled slot keeps its position
      send_item(key_event(8'hFF, 3'b000, 1'b1));
      drain_block();
      set_masks(8'hFE, 8'hFF, 8'h00);
      send_item(key_event(8'h01, 3'b000, 1'b1));
      drain_block();
      set_masks(8'hFF, 8'h00, 8'h00);
      send_item(key_event(8'h01, 3'b000, 1'b1));
      // a table write clears the position of its slot
      send_item(key_event(8'hFF, 3'b000, 1'b1));
      send_item(table_item(0, 5, 8'h33, 3'b000));
      send_item(key_event(8'h01, 3'b000, 1'b1));
   endtask

   task automatic load_sequence(input int slot);
      int         len;
      logic [7:0] code;
      logic [2:0] mods;
      len = ($urandom_range(0, 9) == 0) ? SLOT_LEN : $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
         code = ($urandom_range(0, 2) == 0) ? common_keys[$urandom_range(0, 3)]
                                            : 8'($urandom_range(1, 255));
         mods = 3'($urandom_range(0, 7));
         script[slot][k] = {mods, code};
         send_item(table_item(slot, k, code, mods));
      end
      if (len < SLOT_LEN) begin
         send_item(table_item(slot, len, 8'h00, 3'($urandom_range(0, 7))));
      end
      script_len[slot] = len;
   endtask

   task automatic play_burst();
      int                        pick;
      int                        slot;
      int                        entry;
      logic [ksm_pkg::ENT_W-1:0] ent;
      logic [7:0]                code;
      logic [2:0]                mods;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, NUM_SLOTS - 1);
      if (pick < 65 && script_len[slot] > 0) begin
         for (int k = 0; k < script_len[slot]; k++) begin
            ent  = script[slot][k];
            code = ent[7:0];
            mods = ent[10:8];
            if ($urandom_range(0, 99) < 20) mods = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 6) code = 8'($urandom_range(0, 255));
            send_item(key_event(code, mods, 1'b1));
            if ($urandom_range(0, 99) < 10) send_item(key_event(code, mods, 1'b0));
         end
      end else if (pick < 78) begin
         send_item(key_event(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0));
      end else if (pick < 90) begin
         code = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         send_item(key_event(code, 3'($urandom_range(0, 7)), 1'b1));
      end else begin
         entry = $urandom_range(0, SLOT_LEN - 1);
         code  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         mods  = 3'($urandom_range(0, 7));
         script[slot][entry] = {mods, code};
         if (code == 8'h00 && entry < script_len[slot]) script_len[slot] = entry;
         send_item(table_item(slot, entry, code, mods));
      end
   endtask

   task automatic run_phase(input int idle_pct, input int count);
      int         stop_at;
      logic [7:0] enable;
      stop_at         = items_sent + count;
      sender_idle_pct = idle_pct;
      while (items_sent < stop_at) begin
         drain_block();
         case ($urandom_range(0, 19))
            0:             enable = 8'h00;
            1, 2, 3, 4, 5: enable = 8'hFF;
            default:       enable = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
         endcase
         set_masks(enable, pick_mask(), pick_mask());
         repeat ($urandom_range(1, 3)) load_sequence($urandom_range(0, NUM_SLOTS - 1));
         repeat ($urandom_range(8, 20)) play_burst();
      end
   endtask

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      foreach (script_len[i]) script_len[i] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // table clearing pass after reset
      do @(posedge clock); while (busy);
      run_directed();
      run_phase(18, 250);
      run_phase(86, 250);
      run_phase(0, 250);
      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
